[rtl/core/lkv_pkg.sv]
package lkv_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_W       = 5;
   localparam int KEY_W       = 16;
   localparam int VALUE_W     = 16;
   localparam int CMP_W       = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DATA
   } state_type;

   // outcome of the associative match for the word in flight
   typedef struct packed {
      logic              hit;
      logic              evict;
      logic [SLOT_W-1:0] slot;
   } look_type;

   // clamp the capacity register into 1..MAX_ENTRIES
   function automatic logic [CMP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] c;
      c = CMP_W'(cap);
      if (c == '0) begin
         c = CMP_W'(1);
      end else if (c > CMP_W'(MAX_ENTRIES)) begin
         c = CMP_W'(MAX_ENTRIES);
      end
      return c;
   endfunction

endpackage

[rtl/core/lkv_value_ram.sv]
module lkv_value_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/lkv_tag_array.sv]
module lkv_tag_array (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       upd_en,
   input  logic                       op_put,
   input  logic [lkv_pkg::KEY_W-1:0]  key,
   input  logic [lkv_pkg::CAP_W-1:0]  capacity,
   output lkv_pkg::look_type          look
);

   logic [lkv_pkg::KEY_W-1:0]    key_ff   [lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::KEY_W-1:0]    key_in   [lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::SLOT_W-1:0]   rank_ff  [lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::SLOT_W-1:0]   rank_in  [lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::MAX_ENTRIES-1:0] valid_ff;
   logic [lkv_pkg::MAX_ENTRIES-1:0] valid_in;
   logic [lkv_pkg::COUNT_W-1:0]  count_ff;
   logic [lkv_pkg::COUNT_W-1:0]  count_in;

   logic [lkv_pkg::MAX_ENTRIES-1:0] match;
   logic [lkv_pkg::MAX_ENTRIES-1:0] victim;
   logic [lkv_pkg::MAX_ENTRIES-1:0] valid_left;
   logic [lkv_pkg::SLOT_W-1:0]   hit_slot;
   logic [lkv_pkg::SLOT_W-1:0]   free_slot;
   logic [lkv_pkg::SLOT_W-1:0]   hit_rank;
   logic                         hit;
   logic                         full;
   logic                         evict;

   always_comb begin
      match    = '0;
      victim   = '0;
      hit_slot = '0;
      free_slot = '0;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == key);
         victim[i] = valid_ff[i] &&
                     (lkv_pkg::COUNT_W'(rank_ff[i]) == (count_ff - 1'b1));
         if (match[i]) begin
            hit_slot = lkv_pkg::SLOT_W'(i);
         end
      end
      hit      = |match;
      hit_rank = rank_ff[hit_slot];
      full     = lkv_pkg::CMP_W'(count_ff) >= lkv_pkg::eff_capacity(capacity);
      evict    = !hit && op_put && full;
      valid_left = valid_ff & ~(victim & {lkv_pkg::MAX_ENTRIES{evict}});
      // lowest free slot once the victim is gone
      for (int i = lkv_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_left[i]) begin
            free_slot = lkv_pkg::SLOT_W'(i);
         end
      end
      look.hit   = hit;
      look.evict = evict;
      look.slot  = hit ? hit_slot : free_slot;
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         key_in[i]  = key_ff[i];
      end
      if (upd_en) begin
         if (hit) begin
            // promote: age every entry that was more recent
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[hit_slot] = '0;
         end else if (op_put) begin
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
               if (valid_left[i]) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            valid_in            = valid_left;
            valid_in[free_slot] = 1'b1;
            key_in[free_slot]   = key;
            rank_in[free_slot]  = '0;
            count_in            = evict ? count_ff : count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         key_ff[i] <= key_in[i];
      end
   end

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == lkv_pkg::COUNT_W'($countones(valid_ff)))
      else $error("entry count differs from number of valid entries");

   a_key_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("key present in more than one entry");

   a_evict_keeps_count: assert property (@(posedge clock) disable iff (reset)
      upd_en && evict |=> count_ff == $past(count_ff))
      else $error("insert with eviction changed the entry count");

endmodule

[rtl/core/lru_key_value_cache_core.sv]
// Sequence: an accepted word updates the tags and ranks in ST_LOOK, and its response
//   word is loaded into the response register in ST_DATA once that register is free.
// Flow: no new word is taken in ST_LOOK; the next one may be taken in ST_DATA once the
//   response register is free, since the value RAM's read data is registered.
// Reset: capacity returns to 16 and every entry is marked invalid at once;
//   there is no clearing pass, so the block takes words as soon as reset is released.
module lru_key_value_cache_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] key, [31:16] value
   input  logic        req_tuser,   // [0] operation (0 get, 1 put)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] read_value
   output logic [1:0]  rsp_tuser,   // [0] hit, [1] evicted
   input  logic        csr_wen,
   input  logic [4:0]  csr_wdata    // [4:0] capacity
);

   lkv_pkg::state_type state_ff;
   lkv_pkg::state_type state_in;

   logic [lkv_pkg::CAP_W-1:0]   capacity_ff;

   // word in flight
   logic                        item_op_ff;
   logic [lkv_pkg::KEY_W-1:0]   item_key_ff;
   logic [lkv_pkg::VALUE_W-1:0] item_value_ff;

   // match outcome held across the RAM read
   logic                        look_hit_ff;
   logic                        look_hit_in;
   logic                        look_evict_ff;
   logic                        look_evict_in;

   // response register
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_hit_ff;
   logic                        rsp_evict_ff;
   logic [lkv_pkg::VALUE_W-1:0] rsp_data_ff;
   logic [lkv_pkg::VALUE_W-1:0] rsp_data_in;

   lkv_pkg::look_type           look;
   logic                        req_fire;
   logic                        rsp_free;
   logic                        upd_en;
   logic                        rsp_load;
   logic                        ram_we;
   logic                        ram_re;
   logic [lkv_pkg::VALUE_W-1:0] ram_rdata;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Tag side: keys, valid bits, recency ranks and the entry count. It matches
   // the held key against every entry combinationally and applies the update in ST_LOOK.
   lkv_tag_array u_tags (
      .clock    (clock),
      .reset    (reset),
      .upd_en   (upd_en),
      .op_put   (item_op_ff == lkv_pkg::OP_PUT),
      .key      (item_key_ff),
      .capacity (capacity_ff),
      .look     (look)
   );

   // Value side: written on a put (hit slot or freshly allocated slot),
   // read on a get that hits; its read data is registered and comes back in ST_DATA.
   lkv_value_ram #(
      .DEPTH (lkv_pkg::MAX_ENTRIES),
      .WIDTH (lkv_pkg::VALUE_W)
   ) u_values (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (look.slot),
      .wdata (item_value_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer: IDLE waits for a word, LOOK matches and writes back, DATA
   // captures the RAM output into the response register. A new word may be
   // taken in DATA as soon as the response register is free.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      upd_en     = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = lkv_pkg::ST_LOOK;
            end
         end
         lkv_pkg::ST_LOOK: begin
            upd_en   = 1'b1;
            state_in = lkv_pkg::ST_DATA;
         end
         lkv_pkg::ST_DATA: begin
            if (rsp_free) begin
               rsp_load   = 1'b1;
               req_tready = 1'b1;
               state_in   = req_tvalid ? lkv_pkg::ST_LOOK : lkv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lkv_pkg::ST_IDLE;
         end
      endcase
   end

   assign ram_we = upd_en && (item_op_ff == lkv_pkg::OP_PUT);
   assign ram_re = upd_en && (item_op_ff == lkv_pkg::OP_GET) && look.hit;

   assign look_hit_in   = upd_en ? look.hit   : look_hit_ff;
   assign look_evict_in = upd_en ? look.evict : look_evict_ff;

   // Only a get that hits returns data; everything else reads as zero.
   assign rsp_data_in  = (look_hit_ff && (item_op_ff == lkv_pkg::OP_GET)) ? ram_rdata : '0;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lkv_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            capacity_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold the word until the next one is taken.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_op_ff    <= req_tuser;
         item_key_ff   <= req_tdata[15:0];
         item_value_ff <= req_tdata[31:16];
      end
      look_hit_ff   <= look_hit_in;
      look_evict_ff <= look_evict_in;
      if (rsp_load) begin
         rsp_hit_ff   <= look_hit_ff;
         rsp_evict_ff <= look_evict_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_evict_ff, rsp_hit_ff};

   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == lkv_pkg::ST_LOOK)
      else $error("accepted word did not enter the lookup cycle");

   a_look_to_data: assert property (@(posedge clock) disable iff (reset)
      state_ff == lkv_pkg::ST_LOOK |=> state_ff == lkv_pkg::ST_DATA)
      else $error("lookup cycle not followed by data capture");

   a_hit_excludes_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evict_ff))
      else $error("response reports both hit and eviction");

   a_data_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff != '0) |-> rsp_hit_ff)
      else $error("non-zero read data on a miss");

endmodule
